// ===== sv/ppp_pkg.sv =====
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int DIR_W  = 16;
    localparam int AXIS_W = 48;
    localparam int FOC_W  = 16;
    localparam int ASP_W  = 16;
    localparam int RES_W  = 13;
    localparam int PAS_W  = 24;
    localparam int CFG_DW = 48;
    localparam int CFG_IW = 3;
    localparam int PIX_W  = 21;
    localparam int DEN_W  = 32;
    localparam int DOT_W  = 33;

    // density numerator and divider sizes
    localparam int KPI_W   = 57;
    localparam int DENOM_W = 56;
    localparam logic [KPI_W-1:0]   EIGHT_PI_Q52 = 57'h1921FB54442D184;
    // quotient exceeds 32 bits exactly when the divisor is at most this
    localparam logic [DENOM_W-1:0] OVF_LIMIT    = 56'h1921FB5;

    typedef enum logic [CFG_IW-1:0] {
        CFG_RIGHT  = 3'd0,
        CFG_UP     = 3'd1,
        CFG_FWD    = 3'd2,
        CFG_FOCAL  = 3'd3,
        CFG_ASPECT = 3'd4,
        CFG_WIDTH  = 3'd5,
        CFG_HEIGHT = 3'd6,
        CFG_PAREA  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [AXIS_W-1:0] right_axis;
        logic [AXIS_W-1:0] up_axis;
        logic [AXIS_W-1:0] forward_axis;
        logic [FOC_W-1:0]  focal_length;
        logic [ASP_W-1:0]  aspect;
        logic [RES_W-1:0]  width_pixels;
        logic [RES_W-1:0]  height_pixels;
        logic [PAS_W-1:0]  pixel_area_scale;
    } t_cfg;

    typedef struct packed {
        logic hit;
        logic ovf;
    } t_flags;

endpackage

// ===== sv/ppp_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit in QW bits.
module ppp_div #(
    parameter int NW = 54,
    parameter int DW = 32,
    parameter int QW = 21
) (
    input  logic          i_clk,
    input  logic          i_adv,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [WW-1:0] r_rem [0:QW-2];
    logic [DW-1:0] r_den [0:QW-2];
    logic [QW-1:0] r_quo [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stg
        localparam int B = QW - 1 - k;
        logic [WW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [WW-1:0] w_sh;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem = WW'(i_num);
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_sh = WW'(w_den) << B;
        assign w_ge = (w_rem >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_quo[k] <= w_quo | (QW'(w_ge) << B);
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= w_ge ? (w_rem - w_sh) : w_rem;
                    r_den[k] <= w_den;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== sv/ppp_front.sv =====
`timescale 1ns / 1ps

// Dot products, hit test, divider operands and density divisor: five stages.
module ppp_front #(
    parameter int MAX_RESOLUTION = 4096,
    parameter int RW  = $clog2(MAX_RESOLUTION + 1),
    parameter int NUW = 41 + RW,
    parameter int NVW = 57 + RW
) (
    input  logic                                i_clk,
    input  logic                                i_adv,
    input  logic signed [ppp_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [ppp_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [ppp_pkg::DIR_W-1:0]    i_dir_z,
    input  ppp_pkg::t_cfg                       i_cfg,
    output logic [NUW-1:0]                      o_nu_num,
    output logic [31:0]                         o_nu_den,
    output logic [NVW-1:0]                      o_nv_num,
    output logic [48:0]                         o_nv_den,
    output logic [ppp_pkg::DENOM_W-1:0]         o_denom,
    output ppp_pkg::t_flags                     o_flags
);

    logic [ppp_pkg::AXIS_W-1:0]       w_axis [0:2];
    logic signed [ppp_pkg::DIR_W-1:0] w_dir  [0:2];
    logic signed [16:0]               w_f;
    logic signed [16:0]               w_a;
    logic [RW-1:0]                    w_wc;
    logic [RW-1:0]                    w_hc;

    assign w_axis[0] = i_cfg.right_axis;
    assign w_axis[1] = i_cfg.up_axis;
    assign w_axis[2] = i_cfg.forward_axis;
    assign w_dir[0]  = i_dir_x;
    assign w_dir[1]  = i_dir_y;
    assign w_dir[2]  = i_dir_z;
    assign w_f = $signed({1'b0, i_cfg.focal_length});
    assign w_a = $signed({1'b0, i_cfg.aspect});

    assign w_wc = (int'(i_cfg.width_pixels) > MAX_RESOLUTION) ?
                  RW'(MAX_RESOLUTION) : RW'(i_cfg.width_pixels);
    assign w_hc = (int'(i_cfg.height_pixels) > MAX_RESOLUTION) ?
                  RW'(MAX_RESOLUTION) : RW'(i_cfg.height_pixels);

    // stage 1: nine component products
    logic signed [31:0] r_prod [0:8];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[a*3+c] <= $signed(w_axis[a][c*16 +: 16]) * w_dir[c];
                end
            end
        end
    end

    // stage 2: dx, dy, dz
    logic signed [ppp_pkg::DOT_W-1:0] r_dot [0:2];
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_dot[a] <= ppp_pkg::DOT_W'(r_prod[a*3]) + ppp_pkg::DOT_W'(r_prod[a*3+1])
                          + ppp_pkg::DOT_W'(r_prod[a*3+2]);
            end
        end
    end

    // stage 3: scaled coordinates and z squared
    logic signed [49:0]               r_uf3;
    logic signed [49:0]               r_vf3;
    logic signed [49:0]               r_za3;
    logic signed [ppp_pkg::DOT_W-1:0] r_dz3;
    logic [23:0]                      r_zq3;
    logic [47:0]                      r_sq3;
    logic                             r_apos3;
    logic [23:0]                      w_zq;

    assign w_zq = r_dot[2][31:8];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_uf3   <= r_dot[0] * w_f;
            r_vf3   <= r_dot[1] * w_f;
            r_za3   <= r_dot[2] * w_a;
            r_dz3   <= r_dot[2];
            r_zq3   <= w_zq;
            r_sq3   <= w_zq * w_zq;
            r_apos3 <= (i_cfg.aspect != '0);
        end
    end

    // stage 4: hit test, shifted numerators, z cubed product
    logic signed [56:0] w_uf;
    logic signed [56:0] w_dz128;
    logic signed [56:0] w_vf32;
    logic signed [56:0] w_za;
    logic               w_hit;
    logic [40:0]        r_nu4;
    logic [49:0]        r_nv4;
    logic [31:0]        r_dz4;
    logic [48:0]        r_za4;
    logic [51:0]        r_c3p4;
    logic               r_hit4;

    assign w_uf    = 57'(r_uf3);
    assign w_dz128 = 57'(r_dz3) <<< 7;
    assign w_vf32  = 57'(r_vf3) <<< 5;
    assign w_za    = 57'(r_za3);
    assign w_hit   = (r_dz3 > 0) && r_apos3
                  && !(w_uf < -w_dz128) && !(w_uf > w_dz128)
                  && !(w_vf32 < -w_za) && !(w_vf32 > w_za);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_nu4  <= 41'(w_uf + w_dz128);
            r_nv4  <= 50'(w_vf32 + w_za);
            r_dz4  <= r_dz3[31:0];
            r_za4  <= r_za3[48:0];
            r_c3p4 <= r_sq3[47:20] * r_zq3;
            r_hit4 <= w_hit;
        end
    end

    // stage 5: resolution products and density divisor
    logic [NUW-1:0]                r_nu5;
    logic [50+RW-1:0]              r_nv5;
    logic [31:0]                   r_dz5;
    logic [48:0]                   r_za5;
    logic [ppp_pkg::DENOM_W-1:0]   r_den5;
    logic                          r_hit5;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_nu5  <= r_nu4 * w_wc;
            r_nv5  <= r_nv4 * w_hc;
            r_dz5  <= r_dz4;
            r_za5  <= r_za4;
            r_den5 <= i_cfg.pixel_area_scale * r_c3p4[51:20];
            r_hit5 <= r_hit4;
        end
    end

    assign o_nu_num    = r_nu5;
    assign o_nu_den    = r_dz5;
    assign o_nv_num    = {r_nv5, 7'b0};
    assign o_nv_den    = r_za5;
    assign o_denom     = r_den5;
    assign o_flags.hit = r_hit5;
    assign o_flags.ovf = (r_den5 <= ppp_pkg::OVF_LIMIT);

endmodule

// ===== sv/perspective_pixel_projector.sv =====
`timescale 1ns / 1ps

// Pinhole projection of one Q1.14 ray direction per clock into Q13.8 pixel
// coordinates and a Q16.16 sampling density. The depth from an accepted input
// word to its result word is set by the 32-stage density divider behind
// five stages of products and compares; pixel dividers are 21 stages and
// wait alongside. A new word is taken every cycle; when the output is
// stalled with a word pending, the whole pipeline holds.
// Configuration writes must happen only while no word is in flight.
module perspective_pixel_projector #(
    parameter int MAX_RESOLUTION = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ppp_pkg::DIR_W-1:0]  i_dir_x,
    input  logic signed [ppp_pkg::DIR_W-1:0]  i_dir_y,
    input  logic signed [ppp_pkg::DIR_W-1:0]  i_dir_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_visible,
    output logic [ppp_pkg::PIX_W-1:0]         o_pixel_u,
    output logic [ppp_pkg::PIX_W-1:0]         o_pixel_v,
    output logic [ppp_pkg::DEN_W-1:0]         o_density,
    output logic                              o_density_clipped,
    input  logic                              i_cfg_we,
    input  logic [ppp_pkg::CFG_IW-1:0]        i_cfg_idx,
    input  logic [ppp_pkg::CFG_DW-1:0]        i_cfg_data
);

    localparam int RW     = $clog2(MAX_RESOLUTION + 1);
    localparam int NUW    = 41 + RW;
    localparam int NVW    = 57 + RW;
    localparam int QW_PIX = $clog2(256 * MAX_RESOLUTION + 1);
    localparam int FRONT  = 5;
    localparam int DEPTH  = FRONT + ppp_pkg::DEN_W;
    localparam int PDLY   = ppp_pkg::DEN_W - QW_PIX;

    ppp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.right_axis       <= 48'h0000_0000_4000;
            r_cfg.up_axis          <= 48'h0000_4000_0000;
            r_cfg.forward_axis     <= 48'h4000_0000_0000;
            r_cfg.focal_length     <= 16'd256;
            r_cfg.aspect           <= 16'd4096;
            r_cfg.width_pixels     <= 13'd1024;
            r_cfg.height_pixels    <= 13'd1024;
            r_cfg.pixel_area_scale <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (ppp_pkg::t_cfg_idx'(i_cfg_idx))
                ppp_pkg::CFG_RIGHT:  r_cfg.right_axis       <= i_cfg_data;
                ppp_pkg::CFG_UP:     r_cfg.up_axis          <= i_cfg_data;
                ppp_pkg::CFG_FWD:    r_cfg.forward_axis     <= i_cfg_data;
                ppp_pkg::CFG_FOCAL:  r_cfg.focal_length     <= i_cfg_data[15:0];
                ppp_pkg::CFG_ASPECT: r_cfg.aspect           <= i_cfg_data[15:0];
                ppp_pkg::CFG_WIDTH:  r_cfg.width_pixels     <= i_cfg_data[12:0];
                ppp_pkg::CFG_HEIGHT: r_cfg.height_pixels    <= i_cfg_data[12:0];
                ppp_pkg::CFG_PAREA:  r_cfg.pixel_area_scale <= i_cfg_data[23:0];
            endcase
        end
    end

    logic r_o_valid;
    logic w_adv;

    assign w_adv   = !(r_o_valid && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_o_valid;

    logic [NUW-1:0]                w_nu_num;
    logic [31:0]                   w_nu_den;
    logic [NVW-1:0]                w_nv_num;
    logic [48:0]                   w_nv_den;
    logic [ppp_pkg::DENOM_W-1:0]   w_denom;
    ppp_pkg::t_flags               w_flags;
    logic [QW_PIX-1:0]             w_qu;
    logic [QW_PIX-1:0]             w_qv;
    logic [ppp_pkg::DEN_W-1:0]     w_qd;

    ppp_front #(
        .MAX_RESOLUTION(MAX_RESOLUTION),
        .RW(RW),
        .NUW(NUW),
        .NVW(NVW)
    ) u_front (
        .i_clk(i_clk),
        .i_adv(w_adv),
        .i_dir_x(i_dir_x),
        .i_dir_y(i_dir_y),
        .i_dir_z(i_dir_z),
        .i_cfg(r_cfg),
        .o_nu_num(w_nu_num),
        .o_nu_den(w_nu_den),
        .o_nv_num(w_nv_num),
        .o_nv_den(w_nv_den),
        .o_denom(w_denom),
        .o_flags(w_flags)
    );

    ppp_div #(.NW(NUW), .DW(32), .QW(QW_PIX)) u_div_u (
        .i_clk(i_clk),
        .i_adv(w_adv),
        .i_num(w_nu_num),
        .i_den(w_nu_den),
        .o_quo(w_qu)
    );

    ppp_div #(.NW(NVW), .DW(49), .QW(QW_PIX)) u_div_v (
        .i_clk(i_clk),
        .i_adv(w_adv),
        .i_num(w_nv_num),
        .i_den(w_nv_den),
        .o_quo(w_qv)
    );

    ppp_div #(.NW(ppp_pkg::KPI_W), .DW(ppp_pkg::DENOM_W), .QW(ppp_pkg::DEN_W)) u_div_d (
        .i_clk(i_clk),
        .i_adv(w_adv),
        .i_num(ppp_pkg::EIGHT_PI_Q52),
        .i_den(w_denom),
        .o_quo(w_qd)
    );

    // valid bits alongside the data
    logic [DEPTH-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[DEPTH-2:0], i_valid};
            r_o_valid <= r_vld[DEPTH-1];
        end
    end

    // align flags and pixel quotients with the density quotient
    ppp_pkg::t_flags   r_flg [0:ppp_pkg::DEN_W-1];
    logic [QW_PIX-1:0] r_pu  [0:PDLY-1];
    logic [QW_PIX-1:0] r_pv  [0:PDLY-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_flg[0] <= w_flags;
            for (int k = 1; k < ppp_pkg::DEN_W; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
            r_pu[0] <= w_qu;
            r_pv[0] <= w_qv;
            for (int k = 1; k < PDLY; k++) begin
                r_pu[k] <= r_pu[k-1];
                r_pv[k] <= r_pv[k-1];
            end
        end
    end

    ppp_pkg::t_flags w_fo;
    assign w_fo = r_flg[ppp_pkg::DEN_W-1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_visible         <= w_fo.hit;
            o_pixel_u         <= w_fo.hit ? ppp_pkg::PIX_W'(r_pu[PDLY-1]) : '0;
            o_pixel_v         <= w_fo.hit ? ppp_pkg::PIX_W'(r_pv[PDLY-1]) : '0;
            o_density         <= !w_fo.hit ? '0 : (w_fo.ovf ? '1 : w_qd);
            o_density_clipped <= w_fo.hit && w_fo.ovf;
        end
    end

endmodule
